// ===== hw/rtl/crsp_pkg.sv =====
// Shared types, constants and character helpers of the CAT status parser.
`default_nettype none
package crsp_pkg;

  localparam int unsigned BUFFER_LIMIT_DEF = 128;
  localparam int unsigned BUFFER_KEEP_DEF  = 64;

  localparam int unsigned VAL_W   = 42;
  localparam int unsigned ACC_W   = 41;
  localparam int unsigned MFREQ_W = 37;
  localparam int unsigned RIT_W   = 18;
  localparam int unsigned MTR_W   = 32;

  localparam logic [ACC_W-1:0] FREQ_CAP = {ACC_W{1'b1}};
  localparam logic [ACC_W-1:0] S32_MAX  = ACC_W'(32'h7FFF_FFFF);
  localparam logic [ACC_W-1:0] S32_LIM  = ACC_W'(32'h8000_0000);

  localparam logic [7:0] CH_SEMI  = 8'h3B;
  localparam logic [7:0] CH_QUERY = 8'h3F;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_ONE   = 8'h31;
  localparam logic [7:0] CH_NINE  = 8'h39;

  typedef enum logic [2:0] {
    F_BYTE    = 3'd0,
    F_MENU    = 3'd1,
    F_CLEAR   = 3'd2,
    F_BATCH   = 3'd3,
    F_PUBLISH = 3'd4,
    F_RESET   = 3'd5
  } func_e;

  typedef enum logic [3:0] {
    K_FREQ, K_RIT, K_RITON, K_TX, K_MODE, K_RXVFO, K_TXVFO, K_SPLIT,
    K_VFOA, K_VFOB, K_CWOFS, K_SMETER, K_POWER, K_SWR, K_END, K_PUBEND
  } kind_e;

  typedef enum logic [1:0] {
    E_OK, E_ERROR, E_SHORT, E_UNKNOWN
  } endc_e;

  typedef enum logic [3:0] {
    C_IF, C_FA, C_FB, C_BIT, C_MD, C_MM, C_SM, C_PC, C_SW, C_UNK
  } code_e;

  typedef enum logic [2:0] {
    S_IDLE, S_WALK, S_DEC, S_EMIT, S_END
  } state_e;

  typedef struct packed {
    logic             step;
    logic             first;
    logic             sign_ok;
    logic [ACC_W-1:0] cap;
  } num_ctl_t;

  // Returns {valid, mode code}.
  function automatic logic [3:0] mode_code(input logic [7:0] c);
    logic [7:0] u;
    logic [3:0] r;
    u = c;
    if (c >= 8'h61 && c <= 8'h7A) u = c - 8'd32;
    case (u)
      8'h31, 8'h4C: r = 4'b1000;
      8'h32, 8'h55: r = 4'b1001;
      8'h33, 8'h43: r = 4'b1010;
      8'h34, 8'h46: r = 4'b1011;
      8'h35, 8'h41: r = 4'b1100;
      8'h36, 8'h44: r = 4'b1101;
      8'h37:        r = 4'b1110;
      8'h39:        r = 4'b1111;
      default:      r = 4'b0000;
    endcase
    return r;
  endfunction

  function automatic logic is_bit(input logic [7:0] c);
    return (c == CH_ZERO) || (c == CH_ONE);
  endfunction

endpackage
`default_nettype wire

// ===== hw/rtl/crsp_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module crsp_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) mem[waddr_i] <= wdata_i;
    if (re_i) rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule
`default_nettype wire

// ===== hw/rtl/crsp_num.sv =====
// Shared decimal accumulator: one character per step, saturating at a cap.
`default_nettype none
module crsp_num import crsp_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             clr_i,
  input  num_ctl_t         ctl_i,
  input  logic [7:0]       char_i,
  output logic [ACC_W-1:0] acc_o,
  output logic             neg_o,
  output logic             ok_o
);

  logic [ACC_W-1:0] acc_q, acc_d, acc_b, sat;
  logic             neg_q, neg_d, bad_q, bad_d, seen_q, seen_d, bad_b, seen_b;
  logic             is_sign, is_dig;
  logic [ACC_W+3:0] wide;
  logic [3:0]       dig;

  always_comb begin
    acc_b   = ctl_i.first ? '0 : acc_q;
    bad_b   = ctl_i.first ? 1'b0 : bad_q;
    seen_b  = ctl_i.first ? 1'b0 : seen_q;
    is_sign = ctl_i.first && ctl_i.sign_ok && (char_i == CH_PLUS || char_i == CH_MINUS);
    is_dig  = (char_i >= CH_ZERO) && (char_i <= CH_NINE);
    dig     = 4'(char_i - CH_ZERO);
    wide    = ({4'b0, acc_b} << 3) + ({4'b0, acc_b} << 1) + (ACC_W+4)'(dig);
    sat     = (wide > {4'b0, ctl_i.cap}) ? ctl_i.cap : wide[ACC_W-1:0];
    acc_d   = acc_q;
    neg_d   = neg_q;
    bad_d   = bad_q;
    seen_d  = seen_q;
    if (clr_i) begin
      acc_d  = '0;
      neg_d  = 1'b0;
      bad_d  = 1'b0;
      seen_d = 1'b0;
    end else if (ctl_i.step) begin
      acc_d  = acc_b;
      bad_d  = bad_b;
      seen_d = seen_b;
      neg_d  = ctl_i.first ? 1'b0 : neg_q;
      if (is_sign) begin
        neg_d = (char_i == CH_MINUS);
      end else if (is_dig) begin
        acc_d  = sat;
        seen_d = 1'b1;
      end else begin
        bad_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q  <= '0;
      neg_q  <= 1'b0;
      bad_q  <= 1'b0;
      seen_q <= 1'b0;
    end else begin
      acc_q  <= acc_d;
      neg_q  <= neg_d;
      bad_q  <= bad_d;
      seen_q <= seen_d;
    end
  end

  assign acc_o = acc_q;
  assign neg_o = neg_q;
  assign ok_o  = seen_q && !bad_q;

endmodule
`default_nettype wire

// ===== hw/rtl/cat_response_status_parser.sv =====
// Top level of the CAT reply status parser: sequencer, status store and output register.
`default_nettype none
// Each item is one command. A received byte of 0x20 or above other than ';' is
// appended to a circular reply buffer held in a RAM; past BUFFER_LIMIT characters
// only the last BUFFER_KEEP are kept by moving the head pointer. A ';' that closes a
// non-empty reply walks the buffer through the single RAM read port, one
// character per cycle, feeding one shared decimal accumulator and the bit and mode
// decoders; a decide state, a pass over the 14 status fields (one compare and update
// per field, stalled by the output) and an end marker follow. A publish produces
// results only while the IF-reply or the dirty flag is set. Menu, clear, batch and
// soft-reset items are handled without leaving the idle state. The input stall is
// high while an item is being worked on. Results leave through an output register,
// so the last result of an item may still wait there while the next item is
// accepted. The reply buffer has no reset; only written entries are read.
module cat_response_status_parser import crsp_pkg::*; #(
  parameter int unsigned BUFFER_LIMIT = BUFFER_LIMIT_DEF,
  parameter int unsigned BUFFER_KEEP  = BUFFER_KEEP_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic [2:0]        func_i,
  input  logic [7:0]        byte_in_i,
  input  logic [13:0]       flag_mask_i,
  input  logic [7:0]        expected_count_i,
  input  logic              pending_kind_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic [3:0]        kind_o,
  output logic signed [VAL_W-1:0] value_o,
  output logic              present_o,
  output logic              changed_o,
  output logic [31:0]       sequence_res_o,
  output logic              batch_complete_o,
  output logic              menu_pending_o,
  output logic              last_o
);

  localparam int unsigned LW    = $clog2(BUFFER_LIMIT + 1);
  localparam int unsigned DEPTH = 1 << LW;

  state_e state_q, state_d;

  // Reply buffer bookkeeping and walk pointers.
  logic [LW-1:0] len_q, hd_q, rd_q, px_q;
  logic          pv_q;
  logic [7:0]    r0_q, rdata;
  code_e         code_q;
  kind_e         bitk_q;

  // Pending updates gathered during the walk.
  logic [13:0]      upd_q;
  logic [7:0]       nbit_q;
  logic             freqok_q, swclr_q, pub_q, ch_q;
  logic [ACC_W-1:0] freql_q;
  logic [MFREQ_W-1:0] freq_q;
  endc_e            endc_q;
  logic [3:0]       kcnt_q;

  // Status store.
  logic [MFREQ_W-1:0] mfreq_q;
  logic [RIT_W-1:0]   rit_q;
  logic [ACC_W-1:0]   vfoa_q, vfob_q;
  logic [7:0]         small_q;
  logic [MTR_W-1:0]   cw_q, sm_q, pc_q, swr_q;
  logic [13:0]        pres_q;
  logic               dirty_q, hadif_q, armed_q;
  logic [7:0]         exp_q, seen_q;
  logic [31:0]        snap_q;

  // Output register.
  logic             ov_q, pr_q, chg_q, bc_q, mn_q, last_q;
  logic [3:0]       kind_q;
  logic [VAL_W-1:0] val_q;
  logic [31:0]      seq_q;

  // Control.
  logic             accept, go_walk, go_pub, issue, out_free, fld_sel, emit_fld, adv, emit_end;
  logic             wr_en, proc;
  logic [LW-1:0]    waddr, raddr;
  num_ctl_t         nctl;
  logic [ACC_W-1:0] acc;
  logic             neg, nok;
  logic [VAL_W-1:0] sval, curv, newv;
  logic [3:0]       mc;

  function automatic code_e code_of(input logic [7:0] a, input logic [7:0] b);
    code_e r;
    r = C_UNK;
    if (a == 8'h49 && b == 8'h46) r = C_IF;
    else if (a == 8'h46 && b == 8'h41) r = C_FA;
    else if (a == 8'h46 && b == 8'h42) r = C_FB;
    else if (a == 8'h46 && (b == 8'h52 || b == 8'h54)) r = C_BIT;
    else if (a == 8'h53 && b == 8'h50) r = C_BIT;
    else if (a == 8'h54 && b == 8'h51) r = C_BIT;
    else if (a == 8'h4D && b == 8'h44) r = C_MD;
    else if (a == 8'h4D && b == 8'h4D) r = C_MM;
    else if (a == 8'h53 && b == 8'h4D) r = C_SM;
    else if (a == 8'h50 && b == 8'h43) r = C_PC;
    else if (a == 8'h53 && b == 8'h57) r = C_SW;
    return r;
  endfunction

  function automatic kind_e bitk_of(input logic [7:0] a, input logic [7:0] b);
    kind_e r;
    if (a == 8'h53) r = K_SPLIT;
    else if (a == 8'h54) r = K_TX;
    else if (b == 8'h52) r = K_RXVFO;
    else r = K_TXVFO;
    return r;
  endfunction

  // Bit position of a one-bit small field in the packed small-field byte.
  function automatic logic [2:0] bpos(input kind_e k);
    logic [2:0] r;
    case (k)
      K_RITON: r = 3'd0;
      K_TX:    r = 3'd1;
      K_RXVFO: r = 3'd5;
      K_TXVFO: r = 3'd6;
      default: r = 3'd7;
    endcase
    return r;
  endfunction

  crsp_ram #(.WIDTH(8), .DEPTH(DEPTH)) u_buf (
    .clk_i   (clk_i),
    .we_i    (wr_en),
    .waddr_i (waddr),
    .wdata_i (byte_in_i),
    .re_i    (issue),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  crsp_num u_num (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .clr_i  (go_walk),
    .ctl_i  (nctl),
    .char_i (rdata),
    .acc_o  (acc),
    .neg_o  (neg),
    .ok_o   (nok)
  );

  // Control outputs of the sequencer.
  always_comb begin
    accept   = in_valid_i && (state_q == S_IDLE);
    go_walk  = accept && (func_i == F_BYTE) && (byte_in_i == CH_SEMI) && (len_q != '0);
    go_pub   = accept && (func_i == F_PUBLISH) && (hadif_q || dirty_q);
    wr_en    = accept && (func_i == F_BYTE) && (byte_in_i != CH_SEMI) &&
               (byte_in_i >= CH_SPACE);
    waddr    = hd_q + len_q;
    raddr    = hd_q + rd_q;
    issue    = (state_q == S_WALK) && (rd_q < len_q);
    proc     = (state_q == S_WALK) && pv_q;
    out_free = !ov_q || !out_stall_i;
    fld_sel  = pub_q || upd_q[kcnt_q];
    emit_fld = (state_q == S_EMIT) && fld_sel && out_free;
    adv      = (state_q == S_EMIT) && (!fld_sel || out_free);
    emit_end = (state_q == S_END) && out_free;
    in_stall_o = (state_q != S_IDLE);

    nctl = '{step: 1'b0, first: 1'b0, sign_ok: 1'b0, cap: FREQ_CAP};
    if (proc && px_q >= LW'(2)) begin
      case (code_q)
        C_IF: begin
          if (px_q <= LW'(12)) begin
            nctl.step  = 1'b1;
            nctl.first = (px_q == LW'(2));
          end else if (px_q >= LW'(18) && px_q <= LW'(22)) begin
            nctl.step    = 1'b1;
            nctl.first   = (px_q == LW'(18));
            nctl.sign_ok = 1'b1;
            nctl.cap     = S32_LIM;
          end
        end
        C_FA, C_FB: begin
          nctl.step  = 1'b1;
          nctl.first = (px_q == LW'(2));
        end
        C_MM, C_SM: begin
          nctl.step    = 1'b1;
          nctl.first   = (px_q == LW'(2));
          nctl.sign_ok = 1'b1;
          nctl.cap     = S32_LIM;
        end
        C_PC, C_SW: begin
          nctl.step  = 1'b1;
          nctl.first = (px_q == LW'(2));
          nctl.cap   = S32_MAX;
        end
        default: ;
      endcase
    end
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (go_walk) state_d = S_WALK;
        else if (go_pub) state_d = S_EMIT;
      end
      S_WALK: if (!issue && !pv_q) state_d = S_DEC;
      S_DEC:  state_d = S_EMIT;
      S_EMIT: if (adv && kcnt_q == 4'(K_SWR)) state_d = S_END;
      S_END:  if (emit_end) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  // Signed accumulator value (positive side clamped to S32_MAX) and mode code of rdata.
  always_comb begin
    if (neg) sval = VAL_W'(0) - {1'b0, acc};
    else sval = (acc > S32_MAX) ? {1'b0, S32_MAX} : {1'b0, acc};
    mc = mode_code(rdata);
  end

  // Current and candidate values of the field under the sweep.
  always_comb begin
    curv = '0;
    newv = '0;
    case (kind_e'(kcnt_q))
      K_FREQ:   begin curv = VAL_W'(mfreq_q); newv = VAL_W'(freq_q); end
      K_RIT:    begin curv = VAL_W'(signed'(rit_q)); newv = sval; end
      K_RITON:  begin curv = VAL_W'(small_q[0]); newv = VAL_W'(nbit_q[0]); end
      K_TX:     begin curv = VAL_W'(small_q[1]); newv = VAL_W'(nbit_q[1]); end
      K_MODE:   begin curv = VAL_W'(small_q[4:2]); newv = VAL_W'(nbit_q[4:2]); end
      K_RXVFO:  begin curv = VAL_W'(small_q[5]); newv = VAL_W'(nbit_q[5]); end
      K_TXVFO:  begin curv = VAL_W'(small_q[6]); newv = VAL_W'(nbit_q[6]); end
      K_SPLIT:  begin curv = VAL_W'(small_q[7]); newv = VAL_W'(nbit_q[7]); end
      K_VFOA:   begin curv = VAL_W'(vfoa_q); newv = VAL_W'(acc); end
      K_VFOB:   begin curv = VAL_W'(vfob_q); newv = VAL_W'(acc); end
      K_CWOFS:  begin curv = VAL_W'(signed'(cw_q)); newv = sval; end
      K_SMETER: begin curv = VAL_W'(signed'(sm_q)); newv = sval; end
      K_POWER:  begin curv = VAL_W'(signed'(pc_q)); newv = sval; end
      K_SWR:    begin curv = VAL_W'(signed'(swr_q)); newv = sval; end
      default:  ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      len_q   <= '0;
      hd_q    <= '0;
      rd_q    <= '0;
      px_q    <= '0;
      pv_q    <= 1'b0;
      r0_q    <= '0;
      code_q  <= C_UNK;
      bitk_q  <= K_TX;
      upd_q   <= '0;
      nbit_q  <= '0;
      freqok_q <= 1'b0;
      freql_q <= '0;
      freq_q  <= '0;
      swclr_q <= 1'b0;
      pub_q   <= 1'b0;
      ch_q    <= 1'b0;
      endc_q  <= E_OK;
      kcnt_q  <= '0;
      mfreq_q <= '0;
      rit_q   <= '0;
      vfoa_q  <= '0;
      vfob_q  <= '0;
      small_q <= '0;
      cw_q    <= '0;
      sm_q    <= '0;
      pc_q    <= '0;
      swr_q   <= '0;
      pres_q  <= '0;
      dirty_q <= 1'b0;
      hadif_q <= 1'b0;
      armed_q <= 1'b0;
      exp_q   <= '0;
      seen_q  <= '0;
      snap_q  <= '0;
      ov_q    <= 1'b0;
      kind_q  <= '0;
      val_q   <= '0;
      pr_q    <= 1'b0;
      chg_q   <= 1'b0;
      seq_q   <= '0;
      bc_q    <= 1'b0;
      mn_q    <= 1'b0;
      last_q  <= 1'b0;
    end else begin
      state_q <= state_d;

      // Item intake.
      if (accept) begin
        case (func_i)
          F_BYTE: begin
            if (go_walk) begin
              rd_q    <= '0;
              pv_q    <= 1'b0;
              upd_q   <= '0;
              swclr_q <= 1'b0;
              pub_q   <= 1'b0;
              ch_q    <= 1'b0;
              kcnt_q  <= '0;
              if (seen_q != 8'hFF) seen_q <= seen_q + 8'd1;
            end else if (wr_en) begin
              if (len_q == LW'(BUFFER_LIMIT)) begin
                hd_q  <= hd_q + LW'(BUFFER_LIMIT + 1 - BUFFER_KEEP);
                len_q <= LW'(BUFFER_KEEP);
              end else begin
                len_q <= len_q + LW'(1);
              end
            end
          end
          F_MENU: armed_q <= pending_kind_i;
          F_CLEAR: begin
            if ((pres_q & flag_mask_i) != '0) begin
              pres_q  <= pres_q & ~flag_mask_i;
              dirty_q <= 1'b1;
            end
          end
          F_BATCH: begin
            hadif_q <= 1'b0;
            exp_q   <= expected_count_i;
            seen_q  <= '0;
          end
          F_PUBLISH: begin
            if (go_pub) begin
              snap_q <= snap_q + 32'd1;
              pub_q  <= 1'b1;
              kcnt_q <= '0;
            end
            dirty_q <= 1'b0;
            hadif_q <= 1'b0;
          end
          F_RESET: begin
            len_q   <= '0;
            hd_q    <= '0;
            mfreq_q <= '0;
            rit_q   <= '0;
            vfoa_q  <= '0;
            vfob_q  <= '0;
            small_q <= '0;
            cw_q    <= '0;
            sm_q    <= '0;
            pc_q    <= '0;
            swr_q   <= '0;
            pres_q  <= '0;
            dirty_q <= 1'b0;
            hadif_q <= 1'b0;
            armed_q <= 1'b0;
            exp_q   <= '0;
            seen_q  <= '0;
            snap_q  <= '0;
          end
          default: ;
        endcase
      end

      // Buffer walk: each read is decoded in the cycle after it is issued.
      if (state_q == S_WALK) begin
        pv_q <= issue;
        px_q <= rd_q;
        if (issue) rd_q <= rd_q + LW'(1);
      end
      if (proc) begin
        if (px_q == LW'(0)) begin
          r0_q <= rdata;
        end else if (px_q == LW'(1)) begin
          code_q <= code_of(r0_q, rdata);
          bitk_q <= bitk_of(r0_q, rdata);
        end else begin
          case (code_q)
            C_IF: begin
              if (px_q == LW'(18)) begin
                freql_q  <= acc;
                freqok_q <= nok;
              end
              if (px_q == LW'(23) && is_bit(rdata)) begin
                upd_q[K_RITON] <= 1'b1;
                nbit_q[0]      <= rdata[0];
              end
              if (px_q == LW'(28) && is_bit(rdata)) begin
                upd_q[K_TX] <= 1'b1;
                nbit_q[1]   <= rdata[0];
              end
              if (px_q == LW'(29) && mc[3]) begin
                upd_q[K_MODE] <= 1'b1;
                nbit_q[4:2]   <= mc[2:0];
              end
              if (px_q == LW'(30) && is_bit(rdata)) begin
                upd_q[K_RXVFO] <= 1'b1;
                nbit_q[5]      <= rdata[0];
              end
              if (px_q == LW'(32) && is_bit(rdata)) begin
                upd_q[K_SPLIT] <= 1'b1;
                nbit_q[7]      <= rdata[0];
              end
            end
            C_BIT: begin
              if (px_q == LW'(2) && is_bit(rdata)) begin
                upd_q[bitk_q]        <= 1'b1;
                nbit_q[bpos(bitk_q)] <= rdata[0];
              end
            end
            C_MD: begin
              if (px_q == LW'(2) && mc[3]) begin
                upd_q[K_MODE] <= 1'b1;
                nbit_q[4:2]   <= mc[2:0];
              end
            end
            default: ;
          endcase
        end
      end

      // Decide: numeric fields, reply-level flags and the end code.
      if (state_q == S_DEC) begin
        len_q  <= '0;
        endc_q <= E_OK;
        if (len_q == LW'(1)) begin
          if (r0_q == CH_QUERY) begin
            armed_q <= 1'b0;
            endc_q  <= E_ERROR;
          end else begin
            endc_q <= E_SHORT;
          end
        end else begin
          case (code_q)
            C_IF: begin
              hadif_q <= 1'b1;
              if (len_q > LW'(18)) begin
                freq_q        <= freql_q[MFREQ_W-1:0];
                upd_q[K_FREQ] <= freqok_q;
              end else begin
                freq_q        <= acc[MFREQ_W-1:0];
                upd_q[K_FREQ] <= (len_q >= LW'(13)) && nok;
              end
              upd_q[K_RIT] <= (len_q >= LW'(23)) && nok;
            end
            C_FA: upd_q[K_VFOA] <= nok;
            C_FB: upd_q[K_VFOB] <= nok;
            C_MM: begin
              if (armed_q) begin
                upd_q[K_CWOFS] <= nok;
                armed_q        <= 1'b0;
              end
            end
            C_SM: upd_q[K_SMETER] <= nok;
            C_PC: upd_q[K_POWER] <= nok;
            C_SW: begin
              if (len_q == LW'(2)) begin
                upd_q[K_SWR] <= pres_q[K_SWR];
                swclr_q      <= 1'b1;
              end else begin
                upd_q[K_SWR] <= nok;
              end
            end
            C_UNK: endc_q <= E_UNKNOWN;
            default: ;
          endcase
        end
      end

      // Field sweep, one field per step: compare, update, report; publish only reports.
      if (adv) kcnt_q <= kcnt_q + 4'd1;
      if (emit_fld && !pub_q) begin
        if (kcnt_q == 4'(K_SWR) && swclr_q) begin
          pres_q[K_SWR] <= 1'b0;
          ch_q          <= 1'b1;
        end else begin
          pres_q[kcnt_q] <= 1'b1;
          if (!pres_q[kcnt_q] || curv != newv) ch_q <= 1'b1;
          case (kind_e'(kcnt_q))
            K_FREQ:   mfreq_q <= freq_q;
            K_RIT:    rit_q <= sval[RIT_W-1:0];
            K_RITON:  small_q[0] <= nbit_q[0];
            K_TX:     small_q[1] <= nbit_q[1];
            K_MODE:   small_q[4:2] <= nbit_q[4:2];
            K_RXVFO:  small_q[5] <= nbit_q[5];
            K_TXVFO:  small_q[6] <= nbit_q[6];
            K_SPLIT:  small_q[7] <= nbit_q[7];
            K_VFOA:   vfoa_q <= acc;
            K_VFOB:   vfob_q <= acc;
            K_CWOFS:  cw_q <= sval[MTR_W-1:0];
            K_SMETER: sm_q <= sval[MTR_W-1:0];
            K_POWER:  pc_q <= sval[MTR_W-1:0];
            K_SWR:    swr_q <= sval[MTR_W-1:0];
            default:  ;
          endcase
        end
      end
      if (emit_end && !pub_q && ch_q) dirty_q <= 1'b1;

      // Output register.
      if (out_free) ov_q <= emit_fld || emit_end;
      if (emit_fld || emit_end) begin
        seq_q  <= snap_q;
        bc_q   <= (exp_q != '0) && (seen_q >= exp_q);
        mn_q   <= armed_q;
        last_q <= emit_end;
      end
      if (emit_fld) begin
        kind_q <= kcnt_q;
        if (pub_q) begin
          val_q <= curv;
          pr_q  <= pres_q[kcnt_q];
          chg_q <= 1'b0;
        end else if (kcnt_q == 4'(K_SWR) && swclr_q) begin
          val_q <= curv;
          pr_q  <= 1'b0;
          chg_q <= 1'b1;
        end else begin
          val_q <= newv;
          pr_q  <= 1'b1;
          chg_q <= !pres_q[kcnt_q] || (curv != newv);
        end
      end
      if (emit_end) begin
        kind_q <= pub_q ? K_PUBEND : K_END;
        val_q  <= pub_q ? '0 : VAL_W'(endc_q);
        pr_q   <= 1'b0;
        chg_q  <= pub_q ? 1'b1 : ch_q;
      end
    end
  end

  assign out_valid_o      = ov_q;
  assign kind_o           = kind_q;
  assign value_o          = val_q;
  assign present_o        = pr_q;
  assign changed_o        = chg_q;
  assign sequence_res_o   = seq_q;
  assign batch_complete_o = bc_q;
  assign menu_pending_o   = mn_q;
  assign last_o           = last_q;

endmodule
`default_nettype wire
